>>> rtl/core/instruction_field_decoder_core_macros.svh
// Assertion helpers for the instruction field decoder core.
// Each macro expects clk and rst_n in scope.
`ifndef INSTRUCTION_FIELD_DECODER_CORE_MACROS_SVH
`define INSTRUCTION_FIELD_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define IFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ifd_pkg.sv
`default_nettype none

package ifd_pkg;

  // Decoded operation numbers
  typedef enum logic [6:0] {
    MN_NONE, MN_JIRL, MN_B, MN_BL, MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
    MN_DBAR, MN_IBAR, MN_SC_W, MN_LL_W,
    MN_LD_B, MN_LD_H, MN_LD_W, MN_ST_B, MN_ST_H, MN_ST_W, MN_LD_BU, MN_LD_HU, MN_PRELD,
    MN_LU12I_W, MN_PCADDU12I,
    MN_CSRRD, MN_CSRWR, MN_CSRXCHG,
    MN_CACOP, MN_INVTLB, MN_IDLE,
    MN_TLBSRCH, MN_TLBRD, MN_TLBWR, MN_TLBFILL, MN_ERTN,
    MN_SLTI, MN_SLTUI, MN_ADDI_W, MN_ANDI, MN_ORI, MN_XORI,
    MN_SLLI_W, MN_SRLI_W, MN_SRAI_W,
    MN_DIV_W, MN_MOD_W, MN_DIV_WU, MN_MOD_WU, MN_BREAK, MN_SYSCALL,
    MN_ADD_W, MN_SUB_W, MN_SLT, MN_SLTU, MN_NOR, MN_AND, MN_OR, MN_XOR,
    MN_SLL_W, MN_SRL_W, MN_SRA_W, MN_MUL_W, MN_MULH_W, MN_MULH_WU,
    MN_RDCNTVL_W, MN_RDCNTID_W, MN_RDCNTVH_W
  } mnem_t;

  // Opcode patterns of the barrier group, bits 27..15
  localparam logic [12:0] OPC_DBAR = 13'h10e4;
  localparam logic [12:0] OPC_IBAR = 13'h10e5;

  // Privileged group: bits 21..17 select the tlb/idle/invtlb subgroup
  localparam logic [4:0] OPC_PRIV_MISC = 5'h04;

  // Bits 14..10 of the TLB / ertn encodings
  localparam logic [4:0] OPC_TLBSRCH = 5'h0a;
  localparam logic [4:0] OPC_TLBRD   = 5'h0b;
  localparam logic [4:0] OPC_TLBWR   = 5'h0c;
  localparam logic [4:0] OPC_TLBFILL = 5'h0d;
  localparam logic [4:0] OPC_ERTN    = 5'h0e;

  // Bits 21..15 of the shift-immediate group
  localparam logic [6:0] OPC_SLLI_W = 7'h01;
  localparam logic [6:0] OPC_SRLI_W = 7'h09;
  localparam logic [6:0] OPC_SRAI_W = 7'h11;

  // Bits 20..15 of the divide / trap group
  localparam logic [5:0] OPC_BREAK   = 6'h14;
  localparam logic [5:0] OPC_SYSCALL = 6'h15;

endpackage

`default_nettype wire

>>> rtl/core/instruction_field_decoder_core.sv
// Instruction field decoder core for the reduced 32-bit LoongArch subset.
//
// Input channel: in_valid / in_stall carry one beat, the raw 32-bit word
// in_instruction. A beat is taken at a rising edge with in_valid high and
// in_stall low.
// Output channel: out_valid / out_stall carry one result beat per input beat:
// mnemonic number (0 = unimplemented), rd / rj / rk, sign- or zero-extended
// immediate (branch offsets in bytes), code/hint field and CSR number.
//
// Throughput: one beat per cycle, sustained while out_stall is low. A beat
// passes three register stages (input capture on the accepting edge,
// opcode-tree decode, field extraction into the output register) before
// out_valid rises.
// Each stage holds its own valid bit; a stage moves when the one after it is
// empty or moving, so bubbles are squeezed out under stall.
// When the receiver stalls, the output beat holds steady and the stages
// behind it keep filling; in_stall rises once all three are full.
// Reset (rst_n low, synchronous) empties the pipeline; nothing else is kept.

`default_nettype none

`include "instruction_field_decoder_core_macros.svh"

module instruction_field_decoder_core
  import ifd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_instruction,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [6:0]              out_mnemonic,
  output logic [4:0]              out_dest_reg,
  output logic [4:0]              out_src_reg_j,
  output logic [4:0]              out_src_reg_k,
  output logic signed [27:0]      out_immediate,
  output logic [14:0]             out_code_field,
  output logic [9:0]              out_csr_number
);

  // stage registers
  logic         s1_valid_r;
  logic [31:0]  s1_word_r;
  logic         s2_valid_r;
  logic [31:0]  s2_word_r;
  mnem_t        s2_mn_r;
  mnem_t        s2_mn_nxt;
  logic         s3_valid_r;
  mnem_t        s3_mn_r;
  logic [4:0]   s3_rd_r;
  logic [4:0]   s3_rj_r;
  logic [4:0]   s3_rk_r;
  logic signed [27:0] s3_imm_r;
  logic signed [27:0] s3_imm_nxt;
  logic [14:0]  s3_code_r;
  logic [14:0]  s3_code_nxt;
  logic [9:0]   s3_csr_r;
  logic [9:0]   s3_csr_nxt;

  logic en1, en2, en3;

  // stage enables: move when the next stage is empty or moving
  assign en3      = !s3_valid_r || !out_stall;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;

  // stage 1: capture the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_valid;
    end
    if (en1 && in_valid) begin
      s1_word_r <= in_instruction;
    end
  end

  // stage 2: walk the opcode tree, most significant bit first
  always_comb begin
    logic [31:0] w;
    w = s1_word_r;
    s2_mn_nxt = MN_NONE;
    priority if (w[31]) begin
      s2_mn_nxt = MN_NONE;
    end else if (w[30]) begin
      // jumps and branches
      unique case (w[29:26])
        4'd3:    s2_mn_nxt = MN_JIRL;
        4'd4:    s2_mn_nxt = MN_B;
        4'd5:    s2_mn_nxt = MN_BL;
        4'd6:    s2_mn_nxt = MN_BEQ;
        4'd7:    s2_mn_nxt = MN_BNE;
        4'd8:    s2_mn_nxt = MN_BLT;
        4'd9:    s2_mn_nxt = MN_BGE;
        4'd10:   s2_mn_nxt = MN_BLTU;
        4'd11:   s2_mn_nxt = MN_BGEU;
        default: s2_mn_nxt = MN_NONE;
      endcase
    end else if (w[29]) begin
      priority if (w[28]) begin
        // barriers
        if (w[27:15] == OPC_DBAR) begin
          s2_mn_nxt = MN_DBAR;
        end else if (w[27:15] == OPC_IBAR) begin
          s2_mn_nxt = MN_IBAR;
        end
      end else if (!w[27]) begin
        // atomics
        s2_mn_nxt = w[24] ? MN_SC_W : MN_LL_W;
      end else begin
        // loads, stores, preld
        unique case (w[26:22])
          5'd0:    s2_mn_nxt = MN_LD_B;
          5'd1:    s2_mn_nxt = MN_LD_H;
          5'd2:    s2_mn_nxt = MN_LD_W;
          5'd4:    s2_mn_nxt = MN_ST_B;
          5'd5:    s2_mn_nxt = MN_ST_H;
          5'd6:    s2_mn_nxt = MN_ST_W;
          5'd8:    s2_mn_nxt = MN_LD_BU;
          5'd9:    s2_mn_nxt = MN_LD_HU;
          5'd10:   s2_mn_nxt = MN_PRELD;
          default: s2_mn_nxt = MN_NONE;
        endcase
      end
    end else if (w[28]) begin
      // upper immediates
      unique case (w[27:25])
        3'd2:    s2_mn_nxt = MN_LU12I_W;
        3'd6:    s2_mn_nxt = MN_PCADDU12I;
        default: s2_mn_nxt = MN_NONE;
      endcase
    end else if (w[27]) begin
      s2_mn_nxt = MN_NONE;
    end else if (w[26]) begin
      // csr and privileged group
      unique case (w[25:24])
        2'd0: begin
          if (w[9:5] == 5'd0) begin
            s2_mn_nxt = MN_CSRRD;
          end else if (w[9:5] == 5'd1) begin
            s2_mn_nxt = MN_CSRWR;
          end else begin
            s2_mn_nxt = MN_CSRXCHG;
          end
        end
        2'd2: begin
          if (w[23:22] == 2'd0) begin
            s2_mn_nxt = MN_CACOP;
          end else if (w[23:22] == 2'd1 && w[21:17] == OPC_PRIV_MISC) begin
            unique case (w[16:15])
              2'd3: s2_mn_nxt = MN_INVTLB;
              2'd1: s2_mn_nxt = MN_IDLE;
              2'd0: begin
                if (w[9:0] == 10'd0) begin
                  unique case (w[14:10])
                    OPC_TLBSRCH: s2_mn_nxt = MN_TLBSRCH;
                    OPC_TLBRD:   s2_mn_nxt = MN_TLBRD;
                    OPC_TLBWR:   s2_mn_nxt = MN_TLBWR;
                    OPC_TLBFILL: s2_mn_nxt = MN_TLBFILL;
                    OPC_ERTN:    s2_mn_nxt = MN_ERTN;
                    default:     s2_mn_nxt = MN_NONE;
                  endcase
                end
              end
              default: s2_mn_nxt = MN_NONE;
            endcase
          end
        end
        default: s2_mn_nxt = MN_NONE;
      endcase
    end else if (w[25]) begin
      // ALU with 12-bit immediate
      unique case (w[24:22])
        3'd0:    s2_mn_nxt = MN_SLTI;
        3'd1:    s2_mn_nxt = MN_SLTUI;
        3'd2:    s2_mn_nxt = MN_ADDI_W;
        3'd5:    s2_mn_nxt = MN_ANDI;
        3'd6:    s2_mn_nxt = MN_ORI;
        3'd7:    s2_mn_nxt = MN_XORI;
        default: s2_mn_nxt = MN_NONE;
      endcase
    end else if (w[24] || w[23]) begin
      s2_mn_nxt = MN_NONE;
    end else if (w[22]) begin
      // shifts by immediate
      unique case (w[21:15])
        OPC_SLLI_W: s2_mn_nxt = MN_SLLI_W;
        OPC_SRLI_W: s2_mn_nxt = MN_SRLI_W;
        OPC_SRAI_W: s2_mn_nxt = MN_SRAI_W;
        default:    s2_mn_nxt = MN_NONE;
      endcase
    end else if (w[21]) begin
      // divide and traps
      unique case (w[20:15])
        6'd0:        s2_mn_nxt = MN_DIV_W;
        6'd1:        s2_mn_nxt = MN_MOD_W;
        6'd2:        s2_mn_nxt = MN_DIV_WU;
        6'd3:        s2_mn_nxt = MN_MOD_WU;
        OPC_BREAK:   s2_mn_nxt = MN_BREAK;
        OPC_SYSCALL: s2_mn_nxt = MN_SYSCALL;
        default:     s2_mn_nxt = MN_NONE;
      endcase
    end else if (w[20]) begin
      // three-register ALU
      unique case (w[19:15])
        5'd0:    s2_mn_nxt = MN_ADD_W;
        5'd2:    s2_mn_nxt = MN_SUB_W;
        5'd4:    s2_mn_nxt = MN_SLT;
        5'd5:    s2_mn_nxt = MN_SLTU;
        5'd8:    s2_mn_nxt = MN_NOR;
        5'd9:    s2_mn_nxt = MN_AND;
        5'd10:   s2_mn_nxt = MN_OR;
        5'd11:   s2_mn_nxt = MN_XOR;
        5'd14:   s2_mn_nxt = MN_SLL_W;
        5'd15:   s2_mn_nxt = MN_SRL_W;
        5'd16:   s2_mn_nxt = MN_SRA_W;
        5'd24:   s2_mn_nxt = MN_MUL_W;
        5'd25:   s2_mn_nxt = MN_MULH_W;
        5'd26:   s2_mn_nxt = MN_MULH_WU;
        default: s2_mn_nxt = MN_NONE;
      endcase
    end else if (w[19:15] == 5'd0 && w[14:13] == 2'd3) begin
      // counter reads
      if (w[12:10] == 3'd0) begin
        s2_mn_nxt = (w[4:0] != 5'd0) ? MN_RDCNTVL_W : MN_RDCNTID_W;
      end else if (w[12:10] == 3'd1) begin
        s2_mn_nxt = MN_RDCNTVH_W;
      end
    end else begin
      s2_mn_nxt = MN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en2 && s1_valid_r) begin
      s2_word_r <= s1_word_r;
      s2_mn_r   <= s2_mn_nxt;
    end
  end

  // stage 3: pick the fields that the operation uses
  always_comb begin
    logic [31:0] w;
    w = s2_word_r;
    s3_imm_nxt  = '0;
    s3_code_nxt = '0;
    s3_csr_nxt  = '0;
    unique case (s2_mn_r)
      MN_JIRL, MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU:
        s3_imm_nxt = {{10{w[25]}}, w[25:10], 2'b00};
      MN_B, MN_BL:
        s3_imm_nxt = {w[9:0], w[25:10], 2'b00};
      MN_LL_W, MN_SC_W:
        s3_imm_nxt = {{14{w[23]}}, w[23:10]};
      MN_LD_B, MN_LD_H, MN_LD_W, MN_ST_B, MN_ST_H, MN_ST_W, MN_LD_BU, MN_LD_HU,
      MN_SLTI, MN_SLTUI, MN_ADDI_W:
        s3_imm_nxt = {{16{w[21]}}, w[21:10]};
      MN_PRELD, MN_CACOP: begin
        s3_imm_nxt  = {{16{w[21]}}, w[21:10]};
        s3_code_nxt = {10'd0, w[4:0]};
      end
      MN_ANDI, MN_ORI, MN_XORI:
        s3_imm_nxt = {16'd0, w[21:10]};
      MN_LU12I_W, MN_PCADDU12I:
        s3_imm_nxt = {{8{w[24]}}, w[24:5]};
      MN_SLLI_W, MN_SRLI_W, MN_SRAI_W:
        s3_imm_nxt = {23'd0, w[14:10]};
      MN_DBAR, MN_IBAR, MN_IDLE, MN_BREAK, MN_SYSCALL:
        s3_code_nxt = w[14:0];
      MN_INVTLB:
        s3_code_nxt = {10'd0, w[4:0]};
      MN_CSRRD, MN_CSRWR, MN_CSRXCHG:
        s3_csr_nxt = w[19:10];
      default: begin
        s3_imm_nxt  = '0;
        s3_code_nxt = '0;
        s3_csr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en3) begin
      s3_valid_r <= s2_valid_r;
    end
    if (en3 && s2_valid_r) begin
      s3_mn_r   <= s2_mn_r;
      s3_rd_r   <= s2_word_r[4:0];
      s3_rj_r   <= s2_word_r[9:5];
      s3_rk_r   <= s2_word_r[14:10];
      s3_imm_r  <= s3_imm_nxt;
      s3_code_r <= s3_code_nxt;
      s3_csr_r  <= s3_csr_nxt;
    end
  end

  // output beat
  assign out_valid      = s3_valid_r;
  assign out_mnemonic   = s3_mn_r;
  assign out_dest_reg   = s3_rd_r;
  assign out_src_reg_j  = s3_rj_r;
  assign out_src_reg_k  = s3_rk_r;
  assign out_immediate  = s3_imm_r;
  assign out_code_field = s3_code_r;
  assign out_csr_number = s3_csr_r;

  // checks
  `IFD_ASSERT_NOW(a_none_fields_zero, out_valid && (s3_mn_r == MN_NONE),
    (s3_imm_r == '0) && (s3_code_r == '0) && (s3_csr_r == '0),
    "unimplemented beat carries nonzero fields")
  `IFD_ASSERT_NOW(a_csr_only_csr_ops, out_valid && (s3_csr_r != '0),
    (s3_mn_r == MN_CSRRD) || (s3_mn_r == MN_CSRWR) || (s3_mn_r == MN_CSRXCHG),
    "csr number set for a non-csr operation")
  `IFD_ASSERT_NEXT(a_s2_holds, s2_valid_r && !en2,
    s2_valid_r && $stable(s2_word_r) && $stable(s2_mn_r),
    "decode stage changed while blocked")
  `IFD_ASSERT_NEXT(a_take_fills_s1, in_valid && !in_stall, s1_valid_r,
    "accepted beat not captured")
  `IFD_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !s2_valid_r, !out_valid,
    "output beat repeated after delivery")

endmodule

`default_nettype wire

>>> sim/tb_instruction_field_decoder_core.sv
`timescale 1ns / 1ps

module tb_instruction_field_decoder_core;
  import ifd_pkg::*;

  // Minor opcode fields used by the decode tree
  localparam logic [3:0] BR_JIRL = 4'h3, BR_B = 4'h4, BR_BL = 4'h5;
  localparam logic [3:0] BR_BEQ = 4'h6, BR_BGEU = 4'hb;
  localparam logic [4:0] LS_LD_B = 5'd0, LS_LD_H = 5'd1, LS_LD_W = 5'd2;
  localparam logic [4:0] LS_ST_B = 5'd4, LS_ST_H = 5'd5, LS_ST_W = 5'd6;
  localparam logic [4:0] LS_LD_BU = 5'd8, LS_LD_HU = 5'd9, LS_PRELD = 5'd10;
  localparam logic [2:0] UI_LU12I_W = 3'd2, UI_PCADDU12I = 3'd6;
  localparam logic [1:0] CSR_GRP_ACCESS = 2'd0, CSR_GRP_PRIV = 2'd2;
  localparam logic [1:0] PRIV_CACOP = 2'd0, PRIV_MISC = 2'd1;
  localparam logic [1:0] MISC_TLB = 2'd0, MISC_IDLE = 2'd1, MISC_INVTLB = 2'd3;
  localparam logic [4:0] RJ_READ = 5'd0, RJ_WRITE = 5'd1;
  localparam logic [2:0] IMM_ADDI_W = 3'd2, IMM_ANDI = 3'd5;
  localparam logic [5:0] DV_MOD_WU = 6'd3;
  localparam logic [4:0] ALU_ADD_W = 5'd0, ALU_SUB_W = 5'd2, ALU_SLT = 5'd4;
  localparam logic [4:0] ALU_SLTU = 5'd5, ALU_NOR = 5'd8, ALU_AND = 5'd9;
  localparam logic [4:0] ALU_OR = 5'd10, ALU_XOR = 5'd11, ALU_SLL_W = 5'd14;
  localparam logic [4:0] ALU_SRL_W = 5'd15, ALU_SRA_W = 5'd16, ALU_MUL_W = 5'd24;
  localparam logic [4:0] ALU_MULH_W = 5'd25, ALU_MULH_WU = 5'd26;
  localparam logic [1:0] CNT_GROUP = 2'd3;
  localparam logic [2:0] CNT_LOW = 3'd0, CNT_HIGH = 3'd1;

  localparam int NUM_WORDS = 1700;
  localparam int STALL_PCT = 32;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    mnem_t              mnemonic;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_j;
    logic [4:0]         src_reg_k;
    logic signed [27:0] immediate;
    logic [14:0]        code_field;
    logic [9:0]         csr_number;
  } decoded_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [31:0] in_instruction = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [6:0] out_mnemonic;
  logic [4:0] out_dest_reg, out_src_reg_j, out_src_reg_k;
  logic signed [27:0] out_immediate;
  logic [14:0] out_code_field;
  logic [9:0] out_csr_number;

  logic [31:0] word_q[$];
  decoded_t decoded_q[$];
  decoded_t head_res;
  int words_taken = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  logic calm;

  // idle-free stretch in the middle of the run
  assign calm = (words_taken >= 600) && (words_taken < 900);

  instruction_field_decoder_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_instruction(in_instruction),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_mnemonic  (out_mnemonic),
    .out_dest_reg  (out_dest_reg),
    .out_src_reg_j (out_src_reg_j),
    .out_src_reg_k (out_src_reg_k),
    .out_immediate (out_immediate),
    .out_code_field(out_code_field),
    .out_csr_number(out_csr_number)
  );

  // Opcode-tree decode of one word, tested from bit 31 downward
  function automatic decoded_t decode_word(input logic [31:0] w);
    decoded_t d;
    logic [3:0] br_op;
    logic [12:0] bar_op;
    logic [4:0] ls_op;
    logic [2:0] ui_op;
    logic [2:0] imm_op;
    logic [4:0] tlb_op;
    d = '0;
    d.mnemonic = MN_NONE;
    d.dest_reg = w[4:0];
    d.src_reg_j = w[9:5];
    d.src_reg_k = w[14:10];
    br_op = w[29:26];
    bar_op = w[27:15];
    ls_op = w[26:22];
    ui_op = w[27:25];
    imm_op = w[24:22];
    tlb_op = w[14:10];
    if (w[31]) return d;
    // jumps and branches
    if (w[30]) begin
      if (br_op == BR_JIRL) begin
        d.mnemonic = MN_JIRL;
        d.immediate = {{10{w[25]}}, w[25:10], 2'b00};
      end else if (br_op == BR_B || br_op == BR_BL) begin
        d.mnemonic = (br_op == BR_B) ? MN_B : MN_BL;
        d.immediate = {w[9:0], w[25:10], 2'b00};
      end else if (br_op >= BR_BEQ && br_op <= BR_BGEU) begin
        d.mnemonic = mnem_t'(MN_BEQ + (br_op - BR_BEQ));
        d.immediate = {{10{w[25]}}, w[25:10], 2'b00};
      end
      return d;
    end
    // barriers, atomics, loads and stores
    if (w[29]) begin
      if (w[28]) begin
        if (bar_op == OPC_DBAR || bar_op == OPC_IBAR) begin
          d.mnemonic = (bar_op == OPC_DBAR) ? MN_DBAR : MN_IBAR;
          d.code_field = w[14:0];
        end
      end else if (!w[27]) begin
        d.mnemonic = w[24] ? MN_SC_W : MN_LL_W;
        d.immediate = {{14{w[23]}}, w[23:10]};
      end else begin
        case (ls_op)
          LS_LD_B:  d.mnemonic = MN_LD_B;
          LS_LD_H:  d.mnemonic = MN_LD_H;
          LS_LD_W:  d.mnemonic = MN_LD_W;
          LS_ST_B:  d.mnemonic = MN_ST_B;
          LS_ST_H:  d.mnemonic = MN_ST_H;
          LS_ST_W:  d.mnemonic = MN_ST_W;
          LS_LD_BU: d.mnemonic = MN_LD_BU;
          LS_LD_HU: d.mnemonic = MN_LD_HU;
          LS_PRELD: d.mnemonic = MN_PRELD;
          default:  d.mnemonic = MN_NONE;
        endcase
        if (d.mnemonic != MN_NONE) d.immediate = {{16{w[21]}}, w[21:10]};
        if (d.mnemonic == MN_PRELD) d.code_field = {10'b0, w[4:0]};
      end
      return d;
    end
    // upper-immediate group
    if (w[28]) begin
      if (ui_op == UI_LU12I_W || ui_op == UI_PCADDU12I) begin
        d.mnemonic = (ui_op == UI_LU12I_W) ? MN_LU12I_W : MN_PCADDU12I;
        d.immediate = {{8{w[24]}}, w[24:5]};
      end
      return d;
    end
    if (w[27]) return d;
    // CSR access and privileged group
    if (w[26]) begin
      if (w[25:24] == CSR_GRP_ACCESS) begin
        d.mnemonic = (w[9:5] == RJ_READ) ? MN_CSRRD :
                     (w[9:5] == RJ_WRITE) ? MN_CSRWR : MN_CSRXCHG;
        d.csr_number = w[19:10];
      end else if (w[25:24] == CSR_GRP_PRIV) begin
        if (w[23:22] == PRIV_CACOP) begin
          d.mnemonic = MN_CACOP;
          d.immediate = {{16{w[21]}}, w[21:10]};
          d.code_field = {10'b0, w[4:0]};
        end else if (w[23:22] == PRIV_MISC && w[21:17] == OPC_PRIV_MISC) begin
          case (w[16:15])
            MISC_INVTLB: begin
              d.mnemonic = MN_INVTLB;
              d.code_field = {10'b0, w[4:0]};
            end
            MISC_IDLE: begin
              d.mnemonic = MN_IDLE;
              d.code_field = w[14:0];
            end
            MISC_TLB: begin
              if (tlb_op >= OPC_TLBSRCH && tlb_op <= OPC_ERTN && w[9:0] == '0)
                d.mnemonic = mnem_t'(MN_TLBSRCH + (tlb_op - OPC_TLBSRCH));
            end
            default: ;
          endcase
        end
      end
      return d;
    end
    // 12-bit immediate ALU group
    if (w[25]) begin
      if (imm_op <= IMM_ADDI_W) begin
        d.mnemonic = mnem_t'(MN_SLTI + imm_op);
        d.immediate = {{16{w[21]}}, w[21:10]};
      end else if (imm_op >= IMM_ANDI) begin
        d.mnemonic = mnem_t'(MN_ANDI + (imm_op - IMM_ANDI));
        d.immediate = {16'b0, w[21:10]};
      end
      return d;
    end
    if (w[24] || w[23]) return d;
    // shift by immediate
    if (w[22]) begin
      case (w[21:15])
        OPC_SLLI_W: d.mnemonic = MN_SLLI_W;
        OPC_SRLI_W: d.mnemonic = MN_SRLI_W;
        OPC_SRAI_W: d.mnemonic = MN_SRAI_W;
        default:    d.mnemonic = MN_NONE;
      endcase
      if (d.mnemonic != MN_NONE) d.immediate = {23'b0, w[14:10]};
      return d;
    end
    // divide and traps
    if (w[21]) begin
      if (w[20:15] <= DV_MOD_WU) begin
        d.mnemonic = mnem_t'(MN_DIV_W + w[20:15]);
      end else if (w[20:15] == OPC_BREAK || w[20:15] == OPC_SYSCALL) begin
        d.mnemonic = (w[20:15] == OPC_BREAK) ? MN_BREAK : MN_SYSCALL;
        d.code_field = w[14:0];
      end
      return d;
    end
    // three-register ALU group
    if (w[20]) begin
      case (w[19:15])
        ALU_ADD_W:   d.mnemonic = MN_ADD_W;
        ALU_SUB_W:   d.mnemonic = MN_SUB_W;
        ALU_SLT:     d.mnemonic = MN_SLT;
        ALU_SLTU:    d.mnemonic = MN_SLTU;
        ALU_NOR:     d.mnemonic = MN_NOR;
        ALU_AND:     d.mnemonic = MN_AND;
        ALU_OR:      d.mnemonic = MN_OR;
        ALU_XOR:     d.mnemonic = MN_XOR;
        ALU_SLL_W:   d.mnemonic = MN_SLL_W;
        ALU_SRL_W:   d.mnemonic = MN_SRL_W;
        ALU_SRA_W:   d.mnemonic = MN_SRA_W;
        ALU_MUL_W:   d.mnemonic = MN_MUL_W;
        ALU_MULH_W:  d.mnemonic = MN_MULH_W;
        ALU_MULH_WU: d.mnemonic = MN_MULH_WU;
        default:     d.mnemonic = MN_NONE;
      endcase
      return d;
    end
    // counter reads
    if (w[19:15] == '0 && w[14:13] == CNT_GROUP) begin
      if (w[12:10] == CNT_LOW) d.mnemonic = (w[4:0] != '0) ? MN_RDCNTVL_W : MN_RDCNTID_W;
      else if (w[12:10] == CNT_HIGH) d.mnemonic = MN_RDCNTVH_W;
    end
    return d;
  endfunction

  // Fixed opcode bits of each operation; free bits get random content
  function automatic logic [31:0] encode_op(input mnem_t m);
    logic [31:0] pattern;
    logic [31:0] fixed;
    logic [31:0] w;
    fixed = 32'hFFC0_0000;
    case (m)
      MN_JIRL:      begin pattern = 32'h4C00_0000; fixed = 32'hFC00_0000; end
      MN_B:         begin pattern = 32'h5000_0000; fixed = 32'hFC00_0000; end
      MN_BL:        begin pattern = 32'h5400_0000; fixed = 32'hFC00_0000; end
      MN_BEQ:       begin pattern = 32'h5800_0000; fixed = 32'hFC00_0000; end
      MN_BNE:       begin pattern = 32'h5C00_0000; fixed = 32'hFC00_0000; end
      MN_BLT:       begin pattern = 32'h6000_0000; fixed = 32'hFC00_0000; end
      MN_BGE:       begin pattern = 32'h6400_0000; fixed = 32'hFC00_0000; end
      MN_BLTU:      begin pattern = 32'h6800_0000; fixed = 32'hFC00_0000; end
      MN_BGEU:      begin pattern = 32'h6C00_0000; fixed = 32'hFC00_0000; end
      MN_DBAR:      begin pattern = 32'h3872_0000; fixed = 32'hFFFF_8000; end
      MN_IBAR:      begin pattern = 32'h3872_8000; fixed = 32'hFFFF_8000; end
      MN_SC_W:      begin pattern = 32'h2100_0000; fixed = 32'hF900_0000; end
      MN_LL_W:      begin pattern = 32'h2000_0000; fixed = 32'hF900_0000; end
      MN_LD_B:      pattern = 32'h2800_0000;
      MN_LD_H:      pattern = 32'h2840_0000;
      MN_LD_W:      pattern = 32'h2880_0000;
      MN_ST_B:      pattern = 32'h2900_0000;
      MN_ST_H:      pattern = 32'h2940_0000;
      MN_ST_W:      pattern = 32'h2980_0000;
      MN_LD_BU:     pattern = 32'h2A00_0000;
      MN_LD_HU:     pattern = 32'h2A40_0000;
      MN_PRELD:     pattern = 32'h2A80_0000;
      MN_LU12I_W:   begin pattern = 32'h1400_0000; fixed = 32'hFE00_0000; end
      MN_PCADDU12I: begin pattern = 32'h1C00_0000; fixed = 32'hFE00_0000; end
      MN_CSRRD:     begin pattern = 32'h0400_0000; fixed = 32'hFF00_03E0; end
      MN_CSRWR:     begin pattern = 32'h0400_0020; fixed = 32'hFF00_03E0; end
      MN_CSRXCHG:   begin pattern = 32'h0400_0000; fixed = 32'hFF00_0000; end
      MN_CACOP:     pattern = 32'h0600_0000;
      MN_INVTLB:    begin pattern = 32'h0649_8000; fixed = 32'hFFFF_8000; end
      MN_IDLE:      begin pattern = 32'h0648_8000; fixed = 32'hFFFF_8000; end
      MN_TLBSRCH:   begin pattern = 32'h0648_2800; fixed = 32'hFFFF_FFFF; end
      MN_TLBRD:     begin pattern = 32'h0648_2C00; fixed = 32'hFFFF_FFFF; end
      MN_TLBWR:     begin pattern = 32'h0648_3000; fixed = 32'hFFFF_FFFF; end
      MN_TLBFILL:   begin pattern = 32'h0648_3400; fixed = 32'hFFFF_FFFF; end
      MN_ERTN:      begin pattern = 32'h0648_3800; fixed = 32'hFFFF_FFFF; end
      MN_SLTI:      pattern = 32'h0200_0000;
      MN_SLTUI:     pattern = 32'h0240_0000;
      MN_ADDI_W:    pattern = 32'h0280_0000;
      MN_ANDI:      pattern = 32'h0340_0000;
      MN_ORI:       pattern = 32'h0380_0000;
      MN_XORI:      pattern = 32'h03C0_0000;
      MN_SLLI_W:    begin pattern = 32'h0040_8000; fixed = 32'hFFFF_8000; end
      MN_SRLI_W:    begin pattern = 32'h0044_8000; fixed = 32'hFFFF_8000; end
      MN_SRAI_W:    begin pattern = 32'h0048_8000; fixed = 32'hFFFF_8000; end
      MN_DIV_W:     begin pattern = 32'h0020_0000; fixed = 32'hFFFF_8000; end
      MN_MOD_W:     begin pattern = 32'h0020_8000; fixed = 32'hFFFF_8000; end
      MN_DIV_WU:    begin pattern = 32'h0021_0000; fixed = 32'hFFFF_8000; end
      MN_MOD_WU:    begin pattern = 32'h0021_8000; fixed = 32'hFFFF_8000; end
      MN_BREAK:     begin pattern = 32'h002A_0000; fixed = 32'hFFFF_8000; end
      MN_SYSCALL:   begin pattern = 32'h002A_8000; fixed = 32'hFFFF_8000; end
      MN_ADD_W:     begin pattern = 32'h0010_0000; fixed = 32'hFFFF_8000; end
      MN_SUB_W:     begin pattern = 32'h0011_0000; fixed = 32'hFFFF_8000; end
      MN_SLT:       begin pattern = 32'h0012_0000; fixed = 32'hFFFF_8000; end
      MN_SLTU:      begin pattern = 32'h0012_8000; fixed = 32'hFFFF_8000; end
      MN_NOR:       begin pattern = 32'h0014_0000; fixed = 32'hFFFF_8000; end
      MN_AND:       begin pattern = 32'h0014_8000; fixed = 32'hFFFF_8000; end
      MN_OR:        begin pattern = 32'h0015_0000; fixed = 32'hFFFF_8000; end
      MN_XOR:       begin pattern = 32'h0015_8000; fixed = 32'hFFFF_8000; end
      MN_SLL_W:     begin pattern = 32'h0017_0000; fixed = 32'hFFFF_8000; end
      MN_SRL_W:     begin pattern = 32'h0017_8000; fixed = 32'hFFFF_8000; end
      MN_SRA_W:     begin pattern = 32'h0018_0000; fixed = 32'hFFFF_8000; end
      MN_MUL_W:     begin pattern = 32'h001C_0000; fixed = 32'hFFFF_8000; end
      MN_MULH_W:    begin pattern = 32'h001C_8000; fixed = 32'hFFFF_8000; end
      MN_MULH_WU:   begin pattern = 32'h001D_0000; fixed = 32'hFFFF_8000; end
      MN_RDCNTVL_W: begin pattern = 32'h0000_6000; fixed = 32'hFFFF_FC00; end
      MN_RDCNTID_W: begin pattern = 32'h0000_6000; fixed = 32'hFFFF_FC00; end
      MN_RDCNTVH_W: begin pattern = 32'h0000_6400; fixed = 32'hFFFF_FC00; end
      default:      begin pattern = '0; fixed = '0; end
    endcase
    w = ($urandom() & ~fixed) | pattern;
    // register fields that pick between operations
    if (m == MN_CSRXCHG) w[9:5] = 5'($urandom_range(2, 31));
    if (m == MN_RDCNTVL_W) w[4:0] = 5'($urandom_range(1, 31));
    if (m == MN_RDCNTID_W) w[4:0] = '0;
    return w;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus: corner words, one word per operation, then the random mix
  initial begin
    logic [31:0] corner_words [25];
    int pick;
    corner_words = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h3872_7FFF,  // all clear, all set, dbar max hint
      32'h53FF_FDFF, 32'h5400_0200,                 // b max and bl min offset
      32'h4E00_0000, 32'h6DFF_FFFF,                 // jirl min, bgeu max
      32'h28A0_0000, 32'h2A80_001F,                 // ld.w min si12, preld hint 31
      32'h2680_0000, 32'h217F_FC00,                 // ll.w with bits 26..25 set, sc.w max
      32'h1500_0000, 32'h1CFF_FFE0,                 // lu12i.w min, pcaddu12i max
      32'h0800_0000, 32'h0100_0000, 32'h0080_0000,  // float / reserved groups
      32'h040F_FC05, 32'h0400_03E0,                 // csrrd max csr, csrxchg rj 31
      32'h0648_2801, 32'h0648_3800, 32'h0648_FFFF,  // tlbsrch low bits set, ertn, idle max
      32'h002A_FFFF, 32'h037F_FC00,                 // syscall max code, andi max
      32'h0000_6800, 32'h0000_63E0                  // counter minor 2, rdcntid with rd 0
    };
    foreach (corner_words[i]) word_q.push_back(corner_words[i]);
    for (int m = 1; m <= MN_RDCNTVH_W; m++) word_q.push_back(encode_op(mnem_t'(m)));
    while (word_q.size() < NUM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        word_q.push_back(encode_op(mnem_t'($urandom_range(1, MN_RDCNTVH_W))));
      else if (pick < 85)
        word_q.push_back(encode_op(mnem_t'($urandom_range(1, MN_RDCNTVH_W))) ^
                         (32'h1 << $urandom_range(0, 31)));
      else
        word_q.push_back($urandom());
    end
  end

  // Driver: one word per beat, random gaps outside the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decoded_q.push_back(decode_word(in_instruction));
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (word_q.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
          in_valid <= 1'b1;
          in_instruction <= word_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest decoded word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with no word pending, mnemonic %0d", out_mnemonic);
          mismatch_count++;
        end else begin
          head_res = decoded_q.pop_front();
          compare_field("mnemonic", 32'(head_res.mnemonic), 32'(out_mnemonic));
          compare_field("dest_reg", 32'(head_res.dest_reg), 32'(out_dest_reg));
          compare_field("src_reg_j", 32'(head_res.src_reg_j), 32'(out_src_reg_j));
          compare_field("src_reg_k", 32'(head_res.src_reg_k), 32'(out_src_reg_k));
          compare_field("immediate", 32'(head_res.immediate), 32'(out_immediate));
          compare_field("code_field", 32'(head_res.code_field), 32'(out_code_field));
          compare_field("csr_number", 32'(head_res.csr_number), 32'(out_csr_number));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End of run: all words sent and all results seen, then drain
  initial begin
    @(posedge rst_n);
    do @(posedge clk);
    while (word_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
